// ----- design/bis_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants for the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

  // Item kinds
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_PIXEL   = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_STRIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_START   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_END     = 3'd5;

  // Register reset values
  localparam logic [15:0] X_STEP_RST    = 16'd256;
  localparam logic [15:0] Y_STEP_RST    = 16'd256;
  localparam logic [15:0] OUT_WIDTH_RST = 16'd1;
  localparam logic [15:0] IN_STRIDE_RST = 16'd1;
  localparam logic [23:0] Y_START_RST   = 24'd0;
  localparam logic [23:0] Y_END_RST     = 24'd0;

  localparam logic [7:0] PIX_MAX = 8'hFF;

  // Neighbour taps
  localparam logic [1:0] TAP_00 = 2'd0;
  localparam logic [1:0] TAP_01 = 2'd1;
  localparam logic [1:0] TAP_10 = 2'd2;
  localparam logic [1:0] TAP_11 = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] load_addr;
    logic [7:0]  load_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       row_end;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic       load_cap;
    logic       restart;
    logic       mul_go;
    logic       base_go;
    logic       adj_go;
    logic       wr_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       mix_a;
    logic       mix_b;
    logic       mix_y;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic red_done;
    logic frame_done;
  } dp_status_t;

endpackage

// ----- design/bis_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- design/bis_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_datapath
// Registers, accumulators, address reduction, frame store and interpolation.
// ----------------------------------------------------------------------------
module bis_datapath #(
  parameter int FRAME_DEPTH = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data,
  input  bis_pkg::in_item_t             item,
  input  bis_pkg::dp_cmd_t              cmd,
  output bis_pkg::dp_status_t           status,
  output bis_pkg::out_item_t            result,
  output logic                          result_strobe
);
  import bis_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(FRAME_DEPTH);
  localparam bit DEPTH_POW2 = (FRAME_DEPTH == (1 << AW));

  // Configuration
  logic [15:0] x_step, y_step, out_width, in_stride;
  logic [23:0] y_start, y_end;

  // Scan state
  logic [23:0] x_acc, y_acc;
  logic [15:0] col;
  logic        frame_done;

  // Pixel work registers
  logic [31:0]   prod, v0, v1;
  logic [7:0]    ld_val;
  logic [AW-1:0] addr_q [4];
  logic [7:0]    p00, p01, p10;
  logic [15:0]   acc_a, acc_b;
  logic [8:0]    term_sum;

  logic [AW-1:0] rem0, rem1;
  logic          red_done;
  logic [AW:0]   inc0, inc1;
  logic [AW-1:0] ram_addr;
  logic [7:0]    rd_data;
  logic [7:0]    fx, fy, wfx, wfy;
  logic [23:0]   ya, yb;
  logic [15:0]   col_inc;
  logic [23:0]   x_inc;
  logic [24:0]   y_inc;
  logic          row_last, frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_step    <= X_STEP_RST;
      y_step    <= Y_STEP_RST;
      out_width <= OUT_WIDTH_RST;
      in_stride <= IN_STRIDE_RST;
      y_start   <= Y_START_RST;
      y_end     <= Y_END_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_STEP:    x_step    <= cfg_data[15:0];
        CFG_Y_STEP:    y_step    <= cfg_data[15:0];
        CFG_OUT_WIDTH: out_width <= cfg_data[15:0];
        CFG_IN_STRIDE: in_stride <= cfg_data[15:0];
        CFG_Y_START:   y_start   <= cfg_data;
        CFG_Y_END:     y_end     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    fx         = x_acc[7:0];
    fy         = y_acc[7:0];
    wfx        = PIX_MAX - fx;
    wfy        = PIX_MAX - fy;
    col_inc    = col + 16'd1;
    x_inc      = x_acc + {8'd0, x_step};
    y_inc      = {1'b0, y_acc} + {9'd0, y_step};
    row_last   = (col_inc == out_width);
    // Compare before the 24-bit wrap so an overflowing advance ends the frame
    frame_last = row_last && (y_inc >= {1'b0, y_end});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_acc      <= 24'd0;
      y_acc      <= Y_START_RST;
      col        <= 16'd0;
      frame_done <= 1'b0;
    end else if (cmd.restart) begin
      x_acc      <= 24'd0;
      y_acc      <= y_start;
      col        <= 16'd0;
      frame_done <= 1'b0;
    end else if (cmd.emit) begin
      if (row_last) begin
        col   <= 16'd0;
        x_acc <= 24'd0;
        y_acc <= y_inc[23:0];
        if (frame_last) begin
          frame_done <= 1'b1;
        end
      end else begin
        col   <= col_inc;
        x_acc <= x_inc;
      end
    end
  end

  // Base address: row * stride + column, and one stride further
  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod <= 32'(y_acc[23:8]) * 32'(in_stride);
    end
    if (cmd.load_cap) begin
      v0     <= {16'd0, item.load_addr};
      ld_val <= item.load_value;
    end else if (cmd.base_go) begin
      v0 <= prod + {16'd0, x_acc[23:8]};
      v1 <= prod + {16'd0, x_acc[23:8]} + {16'd0, in_stride};
    end
  end

  // Reduce v0 and v1 modulo the store depth
  if (DEPTH_POW2) begin : g_pow2
    assign rem0     = v0[AW-1:0];
    assign rem1     = v1[AW-1:0];
    assign red_done = 1'b1;
  end else begin : g_recip
    // Estimate the quotient from a reciprocal of the depth; the estimate is
    // at most one low, so one compare and subtract finishes the remainder.
    localparam int RW = 33 - AW;
    localparam logic [RW-1:0] RECIP = RW'(64'd4294967296 / 64'(FRAME_DEPTH));

    logic [1:0]     cnt;
    logic [RW+31:0] pr0, pr1;
    logic [RW+AW:0] qd0, qd1;
    logic [RW-1:0]  q0, q1;
    logic [AW:0]    d0, d1;

    always_comb begin
      pr0 = (RW+32)'(v0) * (RW+32)'(RECIP);
      pr1 = (RW+32)'(v1) * (RW+32)'(RECIP);
      qd0 = (RW+AW+1)'(q0) * (RW+AW+1)'(DEPTH_W);
      qd1 = (RW+AW+1)'(q1) * (RW+AW+1)'(DEPTH_W);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cnt <= 2'd2;
      end else if (cmd.load_cap || cmd.base_go) begin
        cnt <= 2'd0;
      end else if (cnt != 2'd2) begin
        cnt <= cnt + 2'd1;
      end
      if (cnt == 2'd0) begin
        q0 <= pr0[RW+31:32];
        q1 <= pr1[RW+31:32];
      end
      if (cnt == 2'd1) begin
        d0 <= v0[AW:0] - qd0[AW:0];
        d1 <= v1[AW:0] - qd1[AW:0];
      end
    end

    assign rem0     = (d0 >= DEPTH_W) ? AW'(d0 - DEPTH_W) : d0[AW-1:0];
    assign rem1     = (d1 >= DEPTH_W) ? AW'(d1 - DEPTH_W) : d1[AW-1:0];
    assign red_done = (cnt == 2'd2);
  end

  always_comb begin
    inc0 = {1'b0, rem0} + {{AW{1'b0}}, 1'b1};
    inc1 = {1'b0, rem1} + {{AW{1'b0}}, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (cmd.adj_go) begin
      addr_q[TAP_00] <= rem0;
      addr_q[TAP_01] <= (inc0 == DEPTH_W) ? '0 : inc0[AW-1:0];
      addr_q[TAP_10] <= rem1;
      addr_q[TAP_11] <= (inc1 == DEPTH_W) ? '0 : inc1[AW-1:0];
    end
  end

  assign ram_addr = cmd.wr_en ? rem0 : addr_q[cmd.rd_sel];

  bis_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.wr_en),
    .addr (ram_addr),
    .wdata(ld_val),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        TAP_00:  p00 <= rd_data;
        TAP_01:  p01 <= rd_data;
        TAP_10:  p10 <= rd_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ya = 24'(wfy) * 24'(acc_a);
    yb = 24'(fy) * 24'(acc_b);
  end

  // The column-plus-one tap of the second row comes straight off the read port
  always_ff @(posedge clk) begin
    if (cmd.mix_a) begin
      acc_a <= 16'(p00) * 16'(wfx) + 16'(p01) * 16'(fx);
    end
    if (cmd.mix_b) begin
      acc_b <= 16'(p10) * 16'(wfx) + 16'(rd_data) * 16'(fx);
    end
    if (cmd.mix_y) begin
      // Each term stays below 256 and so does their sum, so the low 8 bits need no clamp
      term_sum <= {1'b0, ya[23:16]} + {1'b0, yb[23:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit;
    end
    if (cmd.emit) begin
      result.out_pixel <= term_sum[7:0];
      result.row_end   <= row_last;
      result.frame_end <= frame_last;
    end
  end

  assign status.red_done   = red_done;
  assign status.frame_done = frame_done;

endmodule

// ----- design/bis_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_ctrl
// Sequencer for loads, restarts and the per-pixel read and mix schedule.
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          kind,
  input  bis_pkg::dp_status_t status,
  output logic                busy,
  output bis_pkg::dp_cmd_t    cmd
);
  import bis_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_RED,
    S_PX_BASE,
    S_PX_RED,
    S_PX_RD0,
    S_PX_RD1,
    S_PX_RD2,
    S_PX_RD3,
    S_PX_MB,
    S_PX_MY,
    S_PX_OUT
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_LOAD: begin
              cmd.load_cap = 1'b1;
              state_next   = S_LD_RED;
            end
            KIND_PIXEL: begin
              // Drop pixel requests once the frame is finished
              if (!status.frame_done) begin
                cmd.mul_go = 1'b1;
                state_next = S_PX_BASE;
              end
            end
            KIND_RESTART: cmd.restart = 1'b1;
            default: ;
          endcase
        end
      end
      S_LD_RED: begin
        if (status.red_done) begin
          cmd.wr_en  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PX_BASE: begin
        cmd.base_go = 1'b1;
        state_next  = S_PX_RED;
      end
      S_PX_RED: begin
        if (status.red_done) begin
          cmd.adj_go = 1'b1;
          state_next = S_PX_RD0;
        end
      end
      S_PX_RD0: begin
        cmd.rd_sel = TAP_00;
        state_next = S_PX_RD1;
      end
      S_PX_RD1: begin
        cmd.rd_sel  = TAP_01;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = TAP_00;
        state_next  = S_PX_RD2;
      end
      S_PX_RD2: begin
        cmd.rd_sel  = TAP_10;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = TAP_01;
        state_next  = S_PX_RD3;
      end
      S_PX_RD3: begin
        cmd.rd_sel  = TAP_11;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = TAP_10;
        cmd.mix_a   = 1'b1;
        state_next  = S_PX_MB;
      end
      S_PX_MB: begin
        cmd.mix_b  = 1'b1;
        state_next = S_PX_MY;
      end
      S_PX_MY: begin
        cmd.mix_y  = 1'b1;
        state_next = S_PX_OUT;
      end
      S_PX_OUT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/bilinear_image_scaler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_scaler_core
// Frame store loader and bilinear 8-bit pixel scaler, command style.
// ----------------------------------------------------------------------------
// Pixel item: busy through base, reduction, four read, mix and output states,
// taking no new item until idle; the result strobe is registered from the output
// state. The four reads go through the single frame store port ahead of the mix
// multipliers. Load item: capture, reduction, store write. Restart and ignored
// items never raise busy. A non power-of-two FRAME_DEPTH reduces by reciprocal.
// Synchronous reset restores registers and scan state; the store is not cleared.
module bilinear_image_scaler_core #(
  parameter int FRAME_DEPTH = 65536
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  bis_pkg::in_item_t              item,
  output bis_pkg::out_item_t             result,
  output logic                           result_strobe,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bis_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  bis_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (item.kind),
    .status(status),
    .busy  (busy),
    .cmd   (cmd)
  );

  bis_datapath #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_strobe(result_strobe)
  );

endmodule

// ----- design/bis_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_checker
// Port-level checks for the bilinear image scaler.
// ----------------------------------------------------------------------------
module bis_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input bis_pkg::in_item_t  item,
  input bis_pkg::out_item_t result,
  input logic               result_strobe
);
  import bis_pkg::*;

  // Result strobes are never back to back
  a_strobe_spaced: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("back-to-back result strobes");

  // A result appears only as the block returns to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> !busy)
    else $error("result strobe while busy");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.frame_end) |-> result.row_end)
    else $error("frame end without row end");

  // A load transaction always holds off the next item for the store write
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.kind == KIND_LOAD) |=> busy)
    else $error("load transaction did not raise busy");

  a_reset_quiet: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !result_strobe)
    else $error("result strobe right after reset");

endmodule

bind bilinear_image_scaler_core bis_checker u_bis_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .item         (item),
  .result       (result),
  .result_strobe(result_strobe)
);
